FILE: rtl/solsrch_pkg.sv
package solsrch_pkg;

  // Default list depth
  localparam int DEPTH_DEF = 16;

  localparam int KEY_W  = 32;
  localparam int POS_W  = 4;
  localparam int STAT_W = 2;
  localparam int MODE_W = 2;

  // Operation codes
  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_TRANS  = 2'd2,
    MODE_MTF    = 2'd3
  } mode_t;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_EMPTY    = 2'd1,
    STAT_NOTFOUND = 2'd2,
    STAT_FULL     = 2'd3
  } status_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CMP  = 3'b010,
    ST_UPD  = 3'b100
  } state_t;

  // Control broadcast to every cell
  typedef struct packed {
    logic  cmp;
    logic  upd;
    mode_t mode;
  } cell_ctl_t;

endpackage

FILE: rtl/solsrch_cell.sv
module solsrch_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  logic                                clk,
  input  solsrch_pkg::cell_ctl_t              ctl,
  input  logic        [CNT_W-1:0]             count,
  input  logic signed [solsrch_pkg::KEY_W-1:0] key,
  // from left neighbor
  input  logic signed [solsrch_pkg::KEY_W-1:0] prev_entry,
  input  logic                                hit_before_in,
  input  logic        [solsrch_pkg::POS_W-1:0] idx_in,
  // from right neighbor
  input  logic signed [solsrch_pkg::KEY_W-1:0] next_entry,
  input  logic                                next_first,
  input  logic                                hit_after_in,
  // to neighbors
  output logic signed [solsrch_pkg::KEY_W-1:0] entry,
  output logic                                first,
  output logic                                hit_before_out,
  output logic                                hit_after_out,
  output logic        [solsrch_pkg::POS_W-1:0] idx_out
);

  localparam logic [CNT_W-1:0]             IDX_CNT = CNT_W'(IDX);
  localparam logic [solsrch_pkg::POS_W-1:0] IDX_LO  = solsrch_pkg::POS_W'(IDX);
  localparam bit                           IS_HEAD = (IDX == 0);

  logic signed [solsrch_pkg::KEY_W-1:0] entry_r;
  logic signed [solsrch_pkg::KEY_W-1:0] entry_nxt;
  logic                                 entry_we;
  logic                                 match_r;
  logic                                 in_list;
  logic                                 shift_zone;

  assign in_list = (IDX_CNT < count);

  // Resolve first match along the row
  assign first          = match_r & ~hit_before_in;
  assign hit_before_out = hit_before_in | match_r;
  assign hit_after_out  = hit_after_in | match_r;
  assign idx_out        = first ? IDX_LO : idx_in;
  assign entry          = entry_r;

  // Cells from the head up to the first match take part in a move to front
  assign shift_zone = ~hit_before_in & (match_r | hit_after_in);

  // Pick the new entry for this cell
  always_comb begin
    entry_we  = 1'b0;
    entry_nxt = entry_r;
    if (ctl.upd) begin
      case (ctl.mode)
        solsrch_pkg::MODE_APPEND: begin
          if (count == IDX_CNT) begin
            entry_we  = 1'b1;
            entry_nxt = key;
          end
        end
        solsrch_pkg::MODE_TRANS: begin
          if (first && !IS_HEAD) begin
            entry_we  = 1'b1;
            entry_nxt = prev_entry;
          end else if (next_first) begin
            entry_we  = 1'b1;
            entry_nxt = next_entry;
          end
        end
        solsrch_pkg::MODE_MTF: begin
          if (shift_zone) begin
            entry_we  = 1'b1;
            entry_nxt = IS_HEAD ? key : prev_entry;
          end
        end
        default: begin
          entry_we = 1'b0;
        end
      endcase
    end
  end

  // Hold entry unless written
  always_ff @(posedge clk) begin
    if (entry_we) begin
      entry_r <= entry_nxt;
    end
  end

  // Register the compare result
  always_ff @(posedge clk) begin
    if (ctl.cmp) begin
      match_r <= in_list && (entry_r == key);
    end
  end

endmodule

FILE: rtl/self_organizing_list_search.sv
// An accepted item passes the compare state, then the update state, and its result is registered on out_.
// A new item is taken only in the idle state, once the last item's update is done;
// the row of cells compares all entries at once and shifts them all together.
// A stalled result holds the update stage until it is taken.
// Reset clears the count and the handshake state; list entries are not cleared
// and are written before they are read.
module self_organizing_list_search #(
  parameter int DEPTH = solsrch_pkg::DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic        [solsrch_pkg::MODE_W-1:0] in_mode,
  input  logic signed [solsrch_pkg::KEY_W-1:0]  in_key,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_found,
  output logic        [solsrch_pkg::POS_W-1:0]  out_position,
  output logic        [solsrch_pkg::STAT_W-1:0] out_status
);

  localparam int                CNT_W     = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0]  DEPTH_CNT = CNT_W'(DEPTH);

  solsrch_pkg::state_t                    state_r, state_nxt;
  logic        [CNT_W-1:0]                count_r, count_nxt;
  solsrch_pkg::mode_t                     mode_r;
  logic signed [solsrch_pkg::KEY_W-1:0]   key_r;
  solsrch_pkg::cell_ctl_t                 ctl;

  logic                                   out_valid_r, out_valid_nxt;
  logic                                   out_found_r, out_found_nxt;
  logic        [solsrch_pkg::POS_W-1:0]   out_position_r, out_position_nxt;
  solsrch_pkg::status_t                   out_status_r, out_status_nxt;

  logic                                   in_acc;
  logic                                   upd_go;

  logic signed [solsrch_pkg::KEY_W-1:0]   ent     [DEPTH];
  logic signed [solsrch_pkg::KEY_W-1:0]   prev_e  [DEPTH];
  logic signed [solsrch_pkg::KEY_W-1:0]   next_e  [DEPTH];
  logic        [DEPTH-1:0]                first_v;
  logic        [DEPTH-1:0]                next_f;
  logic        [DEPTH:0]                  hb;
  logic        [DEPTH:0]                  ha;
  logic        [solsrch_pkg::POS_W-1:0]   idxc    [DEPTH+1];

  logic                                   any_hit;
  logic        [solsrch_pkg::POS_W-1:0]   hit_idx;

  assign in_stall = (state_r != solsrch_pkg::ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign upd_go   = (state_r == solsrch_pkg::ST_UPD) && (!out_valid_r || !out_stall);

  assign ctl.cmp  = (state_r == solsrch_pkg::ST_CMP);
  assign ctl.upd  = upd_go;
  assign ctl.mode = mode_r;

  // Chain ends
  assign hb[0]       = 1'b0;
  assign ha[DEPTH]   = 1'b0;
  assign idxc[0]     = '0;

  // Row of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign prev_e[i] = '0;
    end else begin : g_body
      assign prev_e[i] = ent[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign next_e[i] = '0;
      assign next_f[i] = 1'b0;
    end else begin : g_mid
      assign next_e[i] = ent[i+1];
      assign next_f[i] = first_v[i+1];
    end

    solsrch_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk            (clk),
      .ctl            (ctl),
      .count          (count_r),
      .key            (key_r),
      .prev_entry     (prev_e[i]),
      .hit_before_in  (hb[i]),
      .idx_in         (idxc[i]),
      .next_entry     (next_e[i]),
      .next_first     (next_f[i]),
      .hit_after_in   (ha[i+1]),
      .entry          (ent[i]),
      .first          (first_v[i]),
      .hit_before_out (hb[i+1]),
      .hit_after_out  (ha[i]),
      .idx_out        (idxc[i+1])
    );
  end

  assign any_hit = ha[0];
  assign hit_idx = idxc[DEPTH];

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      solsrch_pkg::ST_IDLE: if (in_acc) state_nxt = solsrch_pkg::ST_CMP;
      solsrch_pkg::ST_CMP:  state_nxt = solsrch_pkg::ST_UPD;
      solsrch_pkg::ST_UPD:  if (upd_go) state_nxt = solsrch_pkg::ST_IDLE;
      default:              state_nxt = solsrch_pkg::ST_IDLE;
    endcase
  end

  // Form the result and the new count
  always_comb begin
    count_nxt        = count_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_found_nxt    = out_found_r;
    out_position_nxt = out_position_r;
    out_status_nxt   = out_status_r;
    if (upd_go) begin
      out_valid_nxt    = 1'b1;
      out_found_nxt    = 1'b0;
      out_position_nxt = '0;
      out_status_nxt   = solsrch_pkg::STAT_OK;
      case (mode_r) inside
        solsrch_pkg::MODE_CLEAR: begin
          count_nxt = '0;
        end
        solsrch_pkg::MODE_APPEND: begin
          if (count_r >= DEPTH_CNT) begin
            out_status_nxt = solsrch_pkg::STAT_FULL;
          end else begin
            out_position_nxt = solsrch_pkg::POS_W'(count_r);
            count_nxt        = count_r + CNT_W'(1);
          end
        end
        solsrch_pkg::MODE_TRANS, solsrch_pkg::MODE_MTF: begin
          if (count_r == '0) begin
            out_status_nxt = solsrch_pkg::STAT_EMPTY;
          end else if (!any_hit) begin
            out_status_nxt = solsrch_pkg::STAT_NOTFOUND;
          end else begin
            out_found_nxt = 1'b1;
            if (mode_r == solsrch_pkg::MODE_TRANS && !first_v[0]) begin
              out_position_nxt = hit_idx - solsrch_pkg::POS_W'(1);
            end
          end
        end
        default: begin
          out_status_nxt = solsrch_pkg::STAT_OK;
        end
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= solsrch_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r <= solsrch_pkg::mode_t'(in_mode);
      key_r  <= in_key;
    end
    out_found_r    <= out_found_nxt;
    out_position_r <= out_position_nxt;
    out_status_r   <= out_status_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_found    = out_found_r;
  assign out_position = out_position_r;
  assign out_status   = out_status_r;

  // Count stays within the list depth
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_CNT)
    else $error("count exceeds depth");

  // At most one cell claims the first match
  a_first_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == solsrch_pkg::ST_UPD) |-> $onehot0(first_v))
    else $error("several first-match cells");

  // An accepted item moves to the compare cycle
  a_accept_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == solsrch_pkg::ST_CMP))
    else $error("accepted item did not reach compare");

  // A new result comes only from the update cycle
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == solsrch_pkg::ST_UPD))
    else $error("result without update");

  // A found key always reports ok status
  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_found_r) |-> (out_status_r == solsrch_pkg::STAT_OK))
    else $error("found with error status");

endmodule

FILE: verif/list_scoreboard_pkg.sv
`timescale 1ns / 100ps

package list_scoreboard_pkg;

  import solsrch_pkg::*;

  typedef struct {
    logic              found;
    logic [POS_W-1:0]  position;
    status_t           status;
  } reply_t;

  class list_scoreboard;

    // Shadow copy of the list and its count
    logic signed [KEY_W-1:0] keys [DEPTH_DEF];
    int                      fill = 0;

    // Replies owed by the block, oldest first
    reply_t pending_replies [$];

    int errors     = 0;
    int n_requests = 0;
    int n_replies  = 0;
    int n_hits     = 0;
    int status_seen [4] = '{0, 0, 0, 0};

    // Apply one request to the shadow list and return the reply it earns
    function reply_t apply_request(mode_t mode, logic signed [KEY_W-1:0] key);
      reply_t                  r;
      int                      hit;
      int                      i;
      logic signed [KEY_W-1:0] moved;
      r = '{found: 1'b0, position: '0, status: STAT_OK};
      case (mode)
        MODE_CLEAR: begin
          fill = 0;
        end
        MODE_APPEND: begin
          if (fill >= DEPTH_DEF) begin
            r.status = STAT_FULL;
          end else begin
            keys[fill] = key;
            r.position = POS_W'(fill);
            fill++;
          end
        end
        default: begin
          if (fill == 0) begin
            r.status = STAT_EMPTY;
          end else begin
            // Take the lowest matching index only
            hit = -1;
            for (i = 0; i < fill; i++)
              if (hit < 0 && keys[i] == key) hit = i;
            if (hit < 0) begin
              r.status = STAT_NOTFOUND;
            end else begin
              r.found = 1'b1;
              if (hit > 0) begin
                moved = keys[hit];
                if (mode == MODE_TRANS) begin
                  // Swap with the predecessor
                  keys[hit]     = keys[hit - 1];
                  keys[hit - 1] = moved;
                  r.position    = POS_W'(hit - 1);
                end else begin
                  // Shift earlier entries back, match goes to the head
                  for (i = hit; i > 0; i--) keys[i] = keys[i - 1];
                  keys[0] = moved;
                end
              end
            end
          end
        end
      endcase
      return r;
    endfunction

    // Record an accepted item and queue its reply
    function void note_request(mode_t mode, logic signed [KEY_W-1:0] key);
      pending_replies.push_back(apply_request(mode, key));
      n_requests++;
    endfunction

    // Compare a delivered reply against the oldest one owed
    function void check_reply(logic found, logic [POS_W-1:0] position,
                              logic [STAT_W-1:0] status);
      reply_t want;
      n_replies++;
      if (pending_replies.size() == 0) begin
        $error("unexpected result: found %0d position %0d status %0d",
               found, position, status);
        errors++;
        return;
      end
      want = pending_replies.pop_front();
      status_seen[want.status]++;
      if (want.found) n_hits++;
      if (found !== want.found) begin
        $error("found: expected %0d, got %0d", want.found, found);
        errors++;
      end
      if (position !== want.position) begin
        $error("position: expected %0d, got %0d", want.position, position);
        errors++;
      end
      if (status !== want.status) begin
        $error("status: expected %0d (%s), got %0d", want.status,
               want.status.name(), status);
        errors++;
      end
    endfunction

  endclass

endpackage

FILE: verif/tb.sv
`timescale 1ns / 100ps

module tb;

  import solsrch_pkg::*;
  import list_scoreboard_pkg::*;

  localparam int N_RANDOM   = 1500;
  localparam int QUIET_MAX  = 2000;
  localparam int DRAIN_WAIT = 10;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic [MODE_W-1:0]        in_mode;
  logic signed [KEY_W-1:0]  in_key;
  logic                     out_valid;
  logic                     out_stall;
  logic                     out_found;
  logic [POS_W-1:0]         out_position;
  logic [STAT_W-1:0]        out_status;

  list_scoreboard sb;
  int             sent;
  int             quiet = 0;
  int             backpressure_run = 0;
  int             backpressure_max = 0;

  self_organizing_list_search DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_mode      (in_mode),
    .in_key       (in_key),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_found    (out_found),
    .out_position (out_position),
    .out_status   (out_status)
  );

  // 50 MHz clock
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Wait drawn per item, with stretches of back-to-back traffic
  function automatic int draw_wait(int idx);
    if ((idx % 400) >= 200 && (idx % 400) < 260) return 0;
    return $urandom_range(0, 15);
  endfunction

  // Offer one item and hold it until the block takes it
  task automatic send_item(mode_t mode, logic signed [KEY_W-1:0] key);
    int gap;
    gap = draw_wait(sent);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_mode  <= mode;
    in_key   <= key;
    do @(posedge clk); while (in_stall);
    sb.note_request(mode, key);
    sent++;
  endtask

  // Key from a small pool so duplicates and hits are common
  function automatic logic signed [KEY_W-1:0] pool_key();
    return KEY_W'($signed($urandom_range(0, 7)) - 4);
  endfunction

  function automatic logic signed [KEY_W-1:0] edge_key();
    case ($urandom_range(0, 3))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return '1;
      default: return '0;
    endcase
  endfunction

  // Check every result the block hands over
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_reply(out_found, out_position, out_status);
  end

  // Abort when neither channel moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_MAX) begin
        $display("Timeout: no handshake for %0d cycles", QUIET_MAX);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Track the longest stretch of input backpressure
  always @(posedge clk) begin
    if (rst_n && in_valid && in_stall) begin
      backpressure_run <= backpressure_run + 1;
      if (backpressure_run + 1 > backpressure_max)
        backpressure_max <= backpressure_run + 1;
    end else begin
      backpressure_run <= 0;
    end
  end

  // Result side: stall for a drawn number of cycles, then take one result
  initial begin : receiver
    int hold;
    int taken;
    out_stall = 1'b0;
    taken     = 0;
    wait (rst_n === 1'b1);
    forever begin
      // Hold off long enough to fill the block and stall its input
      if (taken == 150 || taken == 800)
        hold = 80;
      else
        hold = draw_wait(taken + 100);
      @(negedge clk);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      taken++;
    end
  end

  // Reset, stimulus, drain and verdict
  initial begin : main
    int                      r;
    int                      i;
    mode_t                   mode;
    logic signed [KEY_W-1:0] key;

    sb               = new();
    sent             = 0;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_mode          = MODE_CLEAR;
    in_key           = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: searches on an empty list, then a clear
    send_item(MODE_TRANS, 32'sh0000_0000);
    send_item(MODE_MTF, -32'sd1);
    send_item(MODE_CLEAR, 32'sh7FFF_FFFF);
    // Fill the list with extremes and a duplicate pair
    send_item(MODE_APPEND, 32'sh8000_0000);
    send_item(MODE_APPEND, 32'sh7FFF_FFFF);
    send_item(MODE_APPEND, -32'sd1);
    send_item(MODE_APPEND, 32'sd0);
    send_item(MODE_APPEND, 32'sd5);
    send_item(MODE_APPEND, 32'sd5);
    for (i = 0; i < 10; i++) send_item(MODE_APPEND, 32'sd100 + i);
    // Append to a full list
    send_item(MODE_APPEND, 32'sd1);
    // Match at the head, first of duplicates, tail to front, missing key
    send_item(MODE_TRANS, 32'sh8000_0000);
    send_item(MODE_TRANS, 32'sd5);
    send_item(MODE_MTF, 32'sd109);
    send_item(MODE_MTF, 32'sd12345);
    send_item(MODE_TRANS, -32'sd1);
    send_item(MODE_CLEAR, 32'sd0);

    // Random: mostly appends and searches for keys known to be present
    for (i = 0; i < N_RANDOM; i++) begin
      r = $urandom_range(0, 99);
      if (r < 4)       mode = MODE_CLEAR;
      else if (r < 34) mode = MODE_APPEND;
      else if (r < 67) mode = MODE_TRANS;
      else             mode = MODE_MTF;
      r = $urandom_range(0, 99);
      if (mode == MODE_TRANS || mode == MODE_MTF) begin
        if (sb.fill > 0 && r < 70) key = sb.keys[$urandom_range(0, sb.fill - 1)];
        else if (r < 85)           key = pool_key();
        else if (r < 95)           key = $urandom;
        else                       key = edge_key();
      end else begin
        if (r < 50)      key = pool_key();
        else if (r < 80) key = $urandom;
        else             key = edge_key();
      end
      send_item(mode, key);
    end
    @(negedge clk);
    in_valid <= 1'b0;

    // Drain outstanding results, then let the pipeline settle
    while (sb.pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Run covered %0d items, %0d results, %0d search hits", sb.n_requests,
             sb.n_replies, sb.n_hits);
    $display("Status mix ok/empty/notfound/full: %0d/%0d/%0d/%0d, longest input stall %0d",
             sb.status_seen[STAT_OK], sb.status_seen[STAT_EMPTY],
             sb.status_seen[STAT_NOTFOUND], sb.status_seen[STAT_FULL], backpressure_max);
    if (sb.errors == 0 && sb.pending_replies.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
